>>> src/ibm_pkg.sv
// ----------------------------------------------------------------------------
// ibm_pkg
// Shared types, codes and helpers for the inode bitmap allocator.
// ----------------------------------------------------------------------------
package ibm_pkg;

    localparam int FIELD_W = 14;   // slot numbers, counts and the register
    localparam int WORD_W  = 32;   // bitmap word held in one memory entry
    localparam int BIT_W   = 5;    // bit index within a word

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_FREE = 2'd1,
        STATUS_BAD_NUM = 2'd2,
        STATUS_ALREADY = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    localparam logic REG_INODE_COUNT = 1'b0;

    // Index of the single set bit of a one-hot word
    function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_W-1:0] oh);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < WORD_W; b++) begin
            for (int k = 0; k < BIT_W; k++) begin
                if (((b >> k) & 1) == 1) begin
                    idx[k] = idx[k] | oh[b];
                end
            end
        end
        return idx;
    endfunction

endpackage

>>> src/ibm_ram.sv
// ----------------------------------------------------------------------------
// ibm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/inode_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// inode_bitmap_allocator
// First-fit slot allocator over a bitmap of used slots, with a free counter.
// ----------------------------------------------------------------------------
// Input words (s_*): s_tuser carries the command (0 allocate, 1 free) and
// s_tdata the 1-based slot number to free. One result word (m_*) follows each
// input word: granted slot number, status and the free count after the command.
// The bitmap sits in a RAM of 32-bit words, one read per cycle. An allocate
// scans from word 0 up to the last active word, one word a cycle, reading up
// to 32 words at MAX_SLOTS = 1024; a free reads its one word and clears the
// bit if set, and a bad number or an allocate with no active slots goes
// straight to the result. One command is in flight at a time, so a new one is
// taken only after the last has loaded its result, as s_tready is idle-only.
// s_tready returns high in the cycle the result is loaded into the output
// register, which holds it while m_tready is low; a following command is then
// processed but waits before loading its result until that word is taken.
// Reset, and any write of inode_count over the APB port, clears the bitmap at
// once through per-word valid bits and sets the free count to
// min(inode_count, MAX_SLOTS). No clearing pass is needed.
// ----------------------------------------------------------------------------
module inode_bitmap_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] release_number, [15:14] zero
    input  logic [0:0]  s_tuser,   // [0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [13:0] granted_number, [27:14] free_count, [31:28] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FW      = ibm_pkg::FIELD_W;
    localparam int WW      = ibm_pkg::WORD_W;
    localparam int BW      = ibm_pkg::BIT_W;
    localparam int NWORDS  = (MAX_SLOTS + WW - 1) / WW;
    localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam logic [FW-1:0] MAX_ACTIVE = FW'(MAX_SLOTS);
    localparam logic [FW-1:0] RESET_COUNT = 14'd1024;
    localparam logic [FW-1:0] RESET_ACTIVE =
        (RESET_COUNT > MAX_ACTIVE) ? MAX_ACTIVE : RESET_COUNT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [WADDR_W-1:0]      word_idx_reg, word_idx_next;
    logic [BW-1:0]           bit_reg, bit_next;
    logic [FW-1:0]           res_granted_reg, res_granted_next;
    ibm_pkg::status_t        res_status_reg, res_status_next;
    logic [FW-1:0]           free_cnt_reg, free_cnt_next;
    logic [FW-1:0]           inode_count_reg, inode_count_next;
    logic [FW-1:0]           active_reg, active_next;
    logic [NWORDS-1:0]       word_vld_reg, word_vld_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [FW-1:0]           m_granted_reg, m_granted_next;
    logic [FW-1:0]           m_free_reg, m_free_next;
    ibm_pkg::status_t        m_status_reg, m_status_next;

    logic                    ram_we, ram_re;
    logic [WADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [WW-1:0]           ram_wdata, ram_rdata;

    logic                    s_accept, cfg_we;
    logic [FW-1:0]           rel_num, rel_m1, active_m1, cfg_count, cfg_active;
    logic [WADDR_W-1:0]      last_word;
    logic [BW-1:0]           last_bits, found_bit;
    logic [WW-1:0]           rd_word, tail_mask, free_bits, lowest;
    logic [WADDR_W+BW-1:0]   found_slot;

    ibm_ram #(
        .WIDTH (WW),
        .DEPTH (NWORDS),
        .AW    (WADDR_W)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_free_reg, m_granted_reg};
    assign m_tuser  = m_status_reg;

    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite && (paddr[2] == ibm_pkg::REG_INODE_COUNT);
    assign cfg_count = pwdata[FW-1:0];
    assign cfg_active = (cfg_count > MAX_ACTIVE) ? MAX_ACTIVE : cfg_count;
    assign prdata    = (paddr[2] == ibm_pkg::REG_INODE_COUNT) ?
                       {{(32-FW){1'b0}}, inode_count_reg} : 32'd0;

    assign rel_num   = s_tdata[FW-1:0];
    assign rel_m1    = rel_num - FW'(1);
    assign active_m1 = active_reg - FW'(1);
    assign last_word = active_m1[BW +: WADDR_W];
    assign last_bits = active_m1[BW-1:0];

    // Words never written since the last clear read as all free
    assign rd_word = word_vld_reg[word_idx_reg] ? ram_rdata : '0;

    // Slots past the active count in the last word look used
    always_comb begin
        for (int b = 0; b < WW; b++) begin
            tail_mask[b] = (word_idx_reg == last_word) && (BW'(b) > last_bits);
        end
    end

    assign free_bits  = ~(rd_word | tail_mask);
    assign lowest     = free_bits & (~free_bits + WW'(1));
    assign found_bit  = ibm_pkg::onehot_index(lowest);
    assign found_slot = {word_idx_reg, found_bit};

    always_comb begin
        state_next       = state_reg;
        word_idx_next    = word_idx_reg;
        bit_next         = bit_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        free_cnt_next    = free_cnt_reg;
        inode_count_next = inode_count_reg;
        active_next      = active_reg;
        word_vld_next    = word_vld_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_granted_next   = m_granted_reg;
        m_free_next      = m_free_reg;
        m_status_next    = m_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = word_idx_reg;
        ram_wdata        = rd_word;
        ram_re           = 1'b0;
        ram_raddr        = word_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_granted_next = '0;
                    res_status_next  = ibm_pkg::STATUS_OK;
                    if (ibm_pkg::cmd_t'(s_tuser[0]) == ibm_pkg::CMD_ALLOC) begin
                        if (active_reg == '0) begin
                            res_status_next = ibm_pkg::STATUS_NO_FREE;
                            state_next      = ST_RESP;
                        end else begin
                            word_idx_next = '0;
                            ram_re        = 1'b1;
                            ram_raddr     = '0;
                            state_next    = ST_SCAN;
                        end
                    end else begin
                        if (rel_num == '0 || rel_num > active_reg) begin
                            res_status_next = ibm_pkg::STATUS_BAD_NUM;
                            state_next      = ST_RESP;
                        end else begin
                            word_idx_next = rel_m1[BW +: WADDR_W];
                            bit_next      = rel_m1[BW-1:0];
                            ram_re        = 1'b1;
                            ram_raddr     = rel_m1[BW +: WADDR_W];
                            state_next    = ST_FREE;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (lowest != '0) begin
                    ram_we                      = 1'b1;
                    ram_wdata                   = rd_word | lowest;
                    word_vld_next[word_idx_reg] = 1'b1;
                    res_granted_next            = FW'(found_slot) + FW'(1);
                    if (free_cnt_reg != '0) begin
                        free_cnt_next = free_cnt_reg - FW'(1);
                    end
                    state_next = ST_RESP;
                end else if (word_idx_reg == last_word) begin
                    res_status_next = ibm_pkg::STATUS_NO_FREE;
                    state_next      = ST_RESP;
                end else begin
                    // advance to the next word, data arrives next cycle
                    word_idx_next = word_idx_reg + WADDR_W'(1);
                    ram_re        = 1'b1;
                    ram_raddr     = word_idx_reg + WADDR_W'(1);
                end
            end
            ST_FREE: begin
                if (!rd_word[bit_reg]) begin
                    res_status_next = ibm_pkg::STATUS_ALREADY;
                end else begin
                    ram_we                      = 1'b1;
                    ram_wdata                   = rd_word & ~(WW'(1) << bit_reg);
                    word_vld_next[word_idx_reg] = 1'b1;
                    if (free_cnt_reg < active_reg) begin
                        free_cnt_next = free_cnt_reg + FW'(1);
                    end
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_status_next  = res_status_reg;
                    m_free_next    = free_cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            inode_count_next = cfg_count;
            active_next      = cfg_active;
            free_cnt_next    = cfg_active;
            word_vld_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            free_cnt_reg    <= RESET_ACTIVE;
            inode_count_reg <= RESET_COUNT;
            active_reg      <= RESET_ACTIVE;
            word_vld_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            free_cnt_reg    <= free_cnt_next;
            inode_count_reg <= inode_count_next;
            active_reg      <= active_next;
            word_vld_reg    <= word_vld_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        word_idx_reg    <= word_idx_next;
        bit_reg         <= bit_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        m_granted_reg   <= m_granted_next;
        m_free_reg      <= m_free_next;
        m_status_reg    <= m_status_next;
    end

`ifndef SYNTHESIS
    a_free_le_active: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= active_reg)
        else $error("free count above active slot count");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> word_idx_reg <= last_word)
        else $error("scan past last active word");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("bitmap read and write in the same cycle");

    a_grant_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_granted_reg != '0 |-> m_status_reg == ibm_pkg::STATUS_OK)
        else $error("slot granted with error status");

    a_grant_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && lowest != '0 |-> FW'(found_slot) < active_reg)
        else $error("granted slot beyond active count");
`endif

endmodule
